@@ rtl/core/fths_pkg.sv @@
// Shared types, constants and helpers for the frame-tagged history slot table.
package fths_pkg;

    // Table geometry
    localparam int SLOTS   = 8;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FRAME_W = 31;
    localparam int REPORT_W = 3;
    localparam int REPLAY_W = 32;

    // Stream payload widths
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_FIELDS_W = 170;
    localparam int OUT_DATA_W = 176;
    localparam int OUT_USER_W = 2;

    typedef logic [SLOT_W-1:0]  t_idx;
    typedef logic [FRAME_W-1:0] t_frame;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_ACK    = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_REWIND = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_IGNORED  = 2'd0,
        STS_HIT      = 2'd1,
        STS_FALLBACK = 2'd2,
        STS_MISS     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_DECIDE,
        ST_SCAN2,
        ST_COMMIT,
        ST_LOAD
    } t_state;

    // Flags from the slot compare unit
    typedef struct packed {
        logic eq;
        logic lt;
        logic gt;
    } t_cmp_res;

    // Slot index reported in its low three bits
    function automatic logic [REPORT_W-1:0] to_report(input t_idx x);
        logic [SLOT_W+REPORT_W-1:0] ext;
        ext = {{REPORT_W{1'b0}}, x};
        return ext[REPORT_W-1:0];
    endfunction

endpackage

@@ rtl/core/frame_tagged_history_slots.sv @@
// Top level of the frame-tagged history slot table with its scan sequencer.
//
//  channel   dir  handshake                    payload
//  s_axis    in   i_s_axis_tvalid/o_..tready   tuser: command; tdata: frame, current_frame
//  m_axis    out  o_m_axis_tvalid/i_..tready   tuser: status;  tdata: slot .. ack_frame
//
//  Acknowledge, find and rewind pass IDLE, SCAN1, DECIDE and LOAD; add also passes
//  SCAN2 and COMMIT before LOAD: the single slot compare unit steps through one slot a cycle,
//  once for the lookup and, for add, once more for the newest/oldest/ack rescan.
//  Reset (synchronous, active low) empties all slots and clears marks at once.
//  The result sits in an output register; a stalled result only holds the next
//  item in its final step, the earlier scan steps go on regardless.
module frame_tagged_history_slots
    import fths_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [30:0] frame, [61:31] current_frame, [63:62] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] command
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [2:0] slot, [33:3] slot_frame, [65:34] replay_count, [66] history_valid,
    // [69:67] newest_slot, [100:70] newest_frame, [103:101] oldest_slot,
    // [134:104] oldest_frame, [135] ack_valid, [138:136] ack_slot,
    // [169:139] ack_frame, [175:170] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [OUT_USER_W-1:0] o_m_axis_tuser
);

    localparam t_idx LAST_IDX = t_idx'(SLOTS - 1);

    t_state r_state, n_state;

    // Slot table
    t_frame     r_tag [SLOTS];
    logic [SLOTS-1:0] r_used;

    // Persistent summary state with frame copies
    logic   r_have_any;
    t_idx   r_newest_idx, r_oldest_idx, r_ack_idx;
    t_frame r_newest_frame, r_oldest_frame, r_ack_frame;
    logic   r_ack_marked;

    // Latched item
    t_cmd   r_cmd;
    t_frame r_frame, r_cur;

    // Scan accumulators
    t_idx   r_idx;
    logic   r_first;
    logic   r_hit, r_emp;
    t_idx   r_hit_idx, r_emp_idx, r_min_idx, r_max_idx;
    t_frame r_acc_min, r_acc_max;

    // Result of the command
    t_status              r_res_status;
    t_idx                 r_res_slot;
    t_frame               r_res_frame;
    logic signed [REPLAY_W-1:0] r_res_replay;

    // Output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic     w_accept, w_last, w_out_free, w_load;
    t_frame   w_entry, w_key;
    logic     w_used;
    t_cmp_res w_cmp;
    t_idx     w_add_idx;
    logic signed [REPLAY_W-1:0] w_replay;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_last     = (r_idx == LAST_IDX);
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_load     = (r_state == ST_LOAD) && w_out_free;
    assign w_entry    = r_tag[r_idx];
    assign w_used     = r_used[r_idx];
    assign w_key      = (r_state == ST_SCAN2) ? r_ack_frame : r_frame;
    assign w_add_idx  = r_hit ? r_hit_idx : (r_emp ? r_emp_idx : r_min_idx);
    assign w_replay   = $signed({1'b0, r_cur}) - $signed({1'b0, r_frame});

    fths_cmp_unit u_cmp (
        .i_entry (w_entry),
        .i_key   (w_key),
        .i_min   (r_acc_min),
        .i_max   (r_acc_max),
        .o_res   (w_cmp)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) n_state = ST_SCAN1;
            end
            ST_SCAN1:  if (w_last) n_state = ST_DECIDE;
            ST_DECIDE: n_state = (r_cmd == CMD_ADD) ? ST_SCAN2 : ST_LOAD;
            ST_SCAN2:  if (w_last) n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_LOAD;
            ST_LOAD:   if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control state: slot usage, summary marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_have_any   <= 1'b0;
            r_newest_idx <= '0;
            r_oldest_idx <= '0;
            r_ack_marked <= 1'b0;
            r_ack_idx    <= '0;
        end else begin
            if (r_state == ST_DECIDE) begin
                if (r_cmd == CMD_ADD) begin
                    r_used[w_add_idx] <= 1'b1;
                end else if (r_cmd == CMD_ACK) begin
                    r_ack_marked <= r_hit;
                    r_ack_idx    <= r_hit ? r_hit_idx : '0;
                end
            end
            if (r_state == ST_COMMIT) begin
                r_have_any <= !r_first;
                if (!r_first) begin
                    r_newest_idx <= r_max_idx;
                    r_oldest_idx <= r_min_idx;
                end
                if (r_ack_marked) begin
                    r_ack_marked <= r_hit;
                    r_ack_idx    <= r_hit ? r_hit_idx : '0;
                end
            end
        end
    end

    // Datapath: item latch, scan accumulators, table writes, result
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_cmd   <= t_cmd'(i_s_axis_tuser[1:0]);
                    r_frame <= i_s_axis_tdata[FRAME_W-1:0];
                    r_cur   <= i_s_axis_tdata[2*FRAME_W-1:FRAME_W];
                    r_idx   <= '0;
                    r_first <= 1'b1;
                    r_hit   <= 1'b0;
                    r_emp   <= 1'b0;
                end
            end
            ST_SCAN1: begin
                // last used match, first empty, first lowest over all slots
                if (w_used && w_cmp.eq) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_idx;
                end
                if (!w_used && !r_emp) begin
                    r_emp     <= 1'b1;
                    r_emp_idx <= r_idx;
                end
                if (r_first || w_cmp.lt) begin
                    r_acc_min <= w_entry;
                    r_min_idx <= r_idx;
                end
                r_first <= 1'b0;
                r_idx   <= w_last ? '0 : r_idx + t_idx'(1);
            end
            ST_DECIDE: begin
                r_res_replay <= '0;
                r_res_slot   <= '0;
                r_res_frame  <= '0;
                case (r_cmd)
                    CMD_ADD: begin
                        r_tag[w_add_idx] <= r_frame;
                        r_res_status     <= STS_HIT;
                        r_res_slot       <= w_add_idx;
                        r_res_frame      <= r_frame;
                    end
                    CMD_ACK: begin
                        r_res_status <= r_hit ? STS_HIT : STS_MISS;
                        if (r_hit) begin
                            r_res_slot  <= r_hit_idx;
                            r_res_frame <= r_frame;
                            r_ack_frame <= r_frame;
                        end
                    end
                    CMD_FIND: begin
                        if (r_frame == '0) begin
                            r_res_status <= STS_IGNORED;
                        end else if (r_hit) begin
                            r_res_status <= STS_HIT;
                            r_res_slot   <= r_hit_idx;
                            r_res_frame  <= r_frame;
                        end else begin
                            r_res_status <= STS_MISS;
                        end
                    end
                    default: begin
                        // rewind
                        if (r_frame == '0 || r_cur == r_frame) begin
                            r_res_status <= STS_IGNORED;
                        end else begin
                            r_res_replay <= w_replay;
                            if (r_hit) begin
                                r_res_status <= STS_HIT;
                                r_res_slot   <= r_hit_idx;
                                r_res_frame  <= r_frame;
                            end else if (r_have_any) begin
                                r_res_status <= STS_FALLBACK;
                                r_res_slot   <= r_oldest_idx;
                                r_res_frame  <= r_oldest_frame;
                            end else begin
                                r_res_status <= STS_MISS;
                            end
                        end
                    end
                endcase
                r_idx   <= '0;
                r_first <= 1'b1;
                r_hit   <= 1'b0;
            end
            ST_SCAN2: begin
                // extremes over used slots and relocation of the ack frame
                if (w_used) begin
                    if (w_cmp.eq) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_idx;
                    end
                    if (r_first || w_cmp.lt) begin
                        r_acc_min <= w_entry;
                        r_min_idx <= r_idx;
                    end
                    if (r_first || w_cmp.gt) begin
                        r_acc_max <= w_entry;
                        r_max_idx <= r_idx;
                    end
                    r_first <= 1'b0;
                end
                r_idx <= w_last ? '0 : r_idx + t_idx'(1);
            end
            ST_COMMIT: begin
                if (!r_first) begin
                    r_newest_frame <= r_acc_max;
                    r_oldest_frame <= r_acc_min;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_user <= r_res_status;
            r_out_data <= {
                {(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                r_ack_marked ? r_ack_frame : t_frame'(0),
                r_ack_marked ? to_report(r_ack_idx) : 3'd0,
                r_ack_marked,
                r_have_any ? r_oldest_frame : t_frame'(0),
                r_have_any ? to_report(r_oldest_idx) : 3'd0,
                r_have_any ? r_newest_frame : t_frame'(0),
                r_have_any ? to_report(r_newest_idx) : 3'd0,
                r_have_any,
                r_res_replay,
                r_res_frame,
                to_report(r_res_slot)
            };
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // Checks
    a_ack_needs_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ack_marked |-> r_have_any)
        else $error("ack marked with no history");

    a_have_any_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_have_any == (|r_used)))
        else $error("history flag disagrees with slot usage");

    a_ack_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && r_ack_marked) |->
            (r_used[r_ack_idx] && (r_tag[r_ack_idx] == r_ack_frame)))
        else $error("ack frame copy stale");

    a_newest_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && r_have_any) |->
            (r_used[r_newest_idx] && (r_tag[r_newest_idx] == r_newest_frame)
             && r_used[r_oldest_idx] && (r_tag[r_oldest_idx] == r_oldest_frame)))
        else $error("newest or oldest copy stale");

endmodule

@@ rtl/core/fths_cmp_unit.sv @@
// Slot compare unit: one table entry against the key and the running extremes.
module fths_cmp_unit
    import fths_pkg::*;
(
    input  t_frame   i_entry,
    input  t_frame   i_key,
    input  t_frame   i_min,
    input  t_frame   i_max,
    output t_cmp_res o_res
);

    // Equality against key, strict order against running min and max
    always_comb begin
        o_res.eq = (i_entry == i_key);
        o_res.lt = (i_entry < i_min);
        o_res.gt = (i_entry > i_max);
    end

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the frame-tagged history slot table.
module testbench;
    import fths_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_LIMIT  = 20000;

    // One result item, split into its fields
    typedef struct {
        t_status      status;
        logic [2:0]   slot;
        t_frame       slot_frame;
        logic [31:0]  replay;
        logic         hist_valid;
        logic [2:0]   newest_slot;
        t_frame       newest_frame;
        logic [2:0]   oldest_slot;
        t_frame       oldest_frame;
        logic         ack_valid;
        logic [2:0]   ack_slot;
        t_frame       ack_frame;
    } t_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // [30:0] frame, [61:31] current_frame, [63:62] zero
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // [1:0] command
    logic [IN_USER_W-1:0]  i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [2:0] slot .. [169:139] ack_frame, [175:170] zero
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // [1:0] status
    logic [OUT_USER_W-1:0] o_m_axis_tuser;

    frame_tagged_history_slots DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Mirror of the slot table
    t_frame  hist_frame [SLOTS];
    bit      hist_used  [SLOTS];
    bit      hist_any;
    int      hist_newest;
    int      hist_oldest;
    bit      ack_on;
    int      ack_at;

    t_report pending_reports[$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    bit      hold_active    = 1'b0;
    t_frame  frame_base     = 31'd1000;
    event    hold_go;

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        i_m_axis_tready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Long hold-off, counted in cycles
    always begin
        @(hold_go);
        hold_active = 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_active = 1'b0;
    end

    // Run limit
    initial begin
        #(LIMIT_CYCLES * 20);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void clear_history();
        for (int i = 0; i < SLOTS; i++) begin
            hist_frame[i] = '0;
            hist_used[i]  = 1'b0;
        end
        hist_any    = 1'b0;
        hist_newest = 0;
        hist_oldest = 0;
        ack_on      = 1'b0;
        ack_at      = 0;
    endfunction

    // Last used slot holding f, or -1
    function automatic int find_slot(t_frame f);
        int hit;
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
            if (hist_used[i] && hist_frame[i] == f)
                hit = i;
        return hit;
    endfunction

    function automatic int mark_ack(t_frame f);
        int hit;
        hit = find_slot(f);
        ack_on = (hit >= 0);
        ack_at = (hit >= 0) ? hit : 0;
        return hit;
    endfunction

    // Newest and oldest: first slot with the extreme frame
    function automatic void rescan_extremes();
        bit     found;
        t_frame lo;
        t_frame hi;
        found = 1'b0;
        lo = '0;
        hi = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (hist_used[i]) begin
                if (!found || hist_frame[i] < lo) begin
                    lo = hist_frame[i];
                    hist_oldest = i;
                end
                if (!found || hist_frame[i] > hi) begin
                    hi = hist_frame[i];
                    hist_newest = i;
                end
                found = 1'b1;
            end
        end
        hist_any = found;
    endfunction

    // Add: matching slot, else first empty, else first holding the lowest frame
    function automatic int store_frame(t_frame f);
        int     idx;
        bit     had_ack;
        t_frame acked;
        t_frame lo;
        idx = find_slot(f);
        for (int i = 0; i < SLOTS && idx < 0; i++)
            if (!hist_used[i])
                idx = i;
        if (idx < 0) begin
            idx = 0;
            lo  = hist_frame[0];
            for (int i = 1; i < SLOTS; i++)
                if (hist_frame[i] < lo) begin
                    lo  = hist_frame[i];
                    idx = i;
                end
        end
        had_ack = ack_on;
        acked   = hist_frame[ack_at];
        hist_frame[idx] = f;
        hist_used[idx]  = 1'b1;
        rescan_extremes();
        // The mark follows its frame; it goes if that frame was overwritten
        if (had_ack)
            void'(mark_ack(acked));
        return idx;
    endfunction

    function automatic t_report predict_report(t_cmd c, t_frame f, t_frame cur);
        t_report r;
        int      hit;
        hit      = -1;
        r.status = STS_IGNORED;
        r.replay = '0;
        case (c)
            CMD_ADD: begin
                hit      = store_frame(f);
                r.status = STS_HIT;
            end
            CMD_ACK: begin
                hit      = mark_ack(f);
                r.status = (hit >= 0) ? STS_HIT : STS_MISS;
            end
            CMD_FIND: begin
                if (f != '0) begin
                    hit      = find_slot(f);
                    r.status = (hit >= 0) ? STS_HIT : STS_MISS;
                end
            end
            default: begin
                // Rewind: frame zero and the current frame itself are ignored
                if (f != '0 && cur != f) begin
                    r.replay = {1'b0, cur} - {1'b0, f};
                    hit      = find_slot(f);
                    if (hit >= 0) begin
                        r.status = STS_HIT;
                    end else if (hist_any) begin
                        hit      = hist_oldest;
                        r.status = STS_FALLBACK;
                    end else begin
                        r.status = STS_MISS;
                    end
                end
            end
        endcase
        if (hit >= 0 && (r.status == STS_HIT || r.status == STS_FALLBACK)) begin
            r.slot       = 3'(hit);
            r.slot_frame = hist_frame[hit];
        end else begin
            r.slot       = '0;
            r.slot_frame = '0;
        end
        r.hist_valid   = hist_any;
        r.newest_slot  = hist_any ? 3'(hist_newest) : 3'd0;
        r.newest_frame = hist_any ? hist_frame[hist_newest] : '0;
        r.oldest_slot  = hist_any ? 3'(hist_oldest) : 3'd0;
        r.oldest_frame = hist_any ? hist_frame[hist_oldest] : '0;
        r.ack_valid    = ack_on;
        r.ack_slot     = ack_on ? 3'(ack_at) : 3'd0;
        r.ack_frame    = ack_on ? hist_frame[ack_at] : '0;
        return r;
    endfunction

    // Offer one item; valid stays high into the next item unless a gap is drawn
    task automatic issue_command(t_cmd c, t_frame f, t_frame cur);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, cur, f};
        i_s_axis_tuser  <= c;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        pending_reports.push_back(predict_report(c, f, cur));
        @(negedge i_clk);
    endtask

    task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_report want;
        t_report got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.status       = t_status'(o_m_axis_tuser);
            got.slot         = o_m_axis_tdata[2:0];
            got.slot_frame   = o_m_axis_tdata[33:3];
            got.replay       = o_m_axis_tdata[65:34];
            got.hist_valid   = o_m_axis_tdata[66];
            got.newest_slot  = o_m_axis_tdata[69:67];
            got.newest_frame = o_m_axis_tdata[100:70];
            got.oldest_slot  = o_m_axis_tdata[103:101];
            got.oldest_frame = o_m_axis_tdata[134:104];
            got.ack_valid    = o_m_axis_tdata[135];
            got.ack_slot     = o_m_axis_tdata[138:136];
            got.ack_frame    = o_m_axis_tdata[169:139];
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result item with none expected", $realtime);
            end else begin
                want = pending_reports.pop_front();
                compare_field("status", want.status, got.status);
                compare_field("slot", want.slot, got.slot);
                compare_field("slot_frame", want.slot_frame, got.slot_frame);
                compare_field("replay_count", want.replay, got.replay);
                compare_field("history_valid", want.hist_valid, got.hist_valid);
                compare_field("newest_slot", want.newest_slot, got.newest_slot);
                compare_field("newest_frame", want.newest_frame, got.newest_frame);
                compare_field("oldest_slot", want.oldest_slot, got.oldest_slot);
                compare_field("oldest_frame", want.oldest_frame, got.oldest_frame);
                compare_field("ack_valid", want.ack_valid, got.ack_valid);
                compare_field("ack_slot", want.ack_slot, got.ack_slot);
                compare_field("ack_frame", want.ack_frame, got.ack_frame);
            end
        end
    end

    // Lookups on an empty table, ignored lookups, acknowledge miss
    task automatic test_empty_table();
        issue_command(CMD_FIND, 31'd5, 31'd0);
        issue_command(CMD_FIND, 31'd0, 31'd0);
        issue_command(CMD_REWIND, 31'd3, 31'd10);
        issue_command(CMD_REWIND, 31'd0, 31'd10);
        issue_command(CMD_REWIND, 31'd7, 31'd7);
        issue_command(CMD_ACK, 31'd5, 31'd0);
    endtask

    // Fill the table, then evict, acknowledge and rewind at the extremes
    task automatic test_fill_and_evict();
        t_frame order [8];
        order = '{31'd104, 31'd100, 31'd107, 31'd101, 31'd106, 31'd102, 31'd105, 31'd103};
        foreach (order[i])
            issue_command(CMD_ADD, order[i], 31'd0);
        issue_command(CMD_ACK, 31'd103, 31'd0);
        // Rewriting the acknowledged frame keeps the mark
        issue_command(CMD_ADD, 31'd103, 31'd0);
        issue_command(CMD_FIND, 31'd107, 31'd0);
        issue_command(CMD_REWIND, 31'd102, 31'd110);
        issue_command(CMD_REWIND, 31'd50, 31'd110);
        issue_command(CMD_REWIND, 31'd106, 31'd101);
        // Evicting the acknowledged slot drops the mark
        issue_command(CMD_ACK, 31'd100, 31'd0);
        issue_command(CMD_ADD, 31'd200, 31'd0);
        issue_command(CMD_ADD, 31'h7FFF_FFFF, 31'd0);
        issue_command(CMD_ADD, 31'd0, 31'd0);
        issue_command(CMD_FIND, 31'd0, 31'd0);
        issue_command(CMD_REWIND, 31'h7FFF_FFFF, 31'd0);
        issue_command(CMD_REWIND, 31'd1, 31'h7FFF_FFFF);
        issue_command(CMD_ACK, 31'd999, 31'd0);
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_output_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_go;
        for (int k = 0; k < 16; k++)
            issue_command((k % 3 == 0) ? CMD_FIND : CMD_ADD, t_frame'(300 + k), 31'd0);
    endtask

    // Frames cluster around a moving base so that lookups hit often
    function automatic t_frame pick_frame();
        case ($urandom_range(0, 9))
            0:       return t_frame'($urandom);
            1:       return t_frame'($urandom_range(0, 3));
            2:       return 31'h7FFF_FFFF - t_frame'($urandom_range(0, 3));
            default: return frame_base + t_frame'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic test_random_traffic(int count, int send_idle, int recv_stall);
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        for (int k = 0; k < count; k++) begin
            int     sel;
            t_cmd   c;
            t_frame f;
            t_frame cur;
            // Game time moves on; now and then jump elsewhere
            if ($urandom_range(0, 19) == 0)
                frame_base = frame_base + t_frame'($urandom_range(1, 12));
            if ($urandom_range(0, 149) == 0 || frame_base > 31'h7FFF_FF00)
                frame_base = t_frame'($urandom_range(1, 32'h7FFF_FF00));
            sel = $urandom_range(0, 99);
            if (sel < 40)
                c = CMD_ADD;
            else if (sel < 60)
                c = CMD_ACK;
            else if (sel < 75)
                c = CMD_FIND;
            else
                c = CMD_REWIND;
            f = pick_frame();
            case ($urandom_range(0, 9))
                6:       cur = f;
                7:       cur = pick_frame();
                8:       cur = t_frame'($urandom);
                9:       cur = f - t_frame'($urandom_range(1, 5));
                default: cur = f + t_frame'($urandom_range(0, 12));
            endcase
            issue_command(c, f, cur);
        end
    endtask

    initial begin
        int waited;
        clear_history();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_fill_and_evict();
        test_output_hold_off();
        test_random_traffic(360, 0, 0);
        test_random_traffic(360, 66, 0);
        test_random_traffic(360, 0, 66);
        test_random_traffic(360, 24, 24);

        // Drain outstanding results, then let the block settle
        i_s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * SLOTS + 8) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            mismatch_count++;
            $display("%0d result items never arrived", pending_reports.size());
        end

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
